[rtl/core/gb_cpu_instruction_subset_assert.svh]
// Assertion macros shared by the instruction execute block.
`ifndef GB_CPU_INSTRUCTION_SUBSET_ASSERT_SVH
`define GB_CPU_INSTRUCTION_SUBSET_ASSERT_SVH

`ifndef SYNTHESIS
// Check a property at every rising edge outside reset.
`define GBCPU_ASSERT(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("gbcpu assertion failed");
// Check a property at every rising edge, reset included.
`define GBCPU_ASSERT_ALWAYS(label, clk, prop) \
  label: assert property (@(posedge clk) prop) \
    else $error("gbcpu assertion failed");
`else
`define GBCPU_ASSERT(label, clk, rst_n, prop)
`define GBCPU_ASSERT_ALWAYS(label, clk, prop)
`endif

`endif

[rtl/core/gbcpu_pkg.sv]
// Package: opcodes, flag positions and payload types of the instruction execute block.
`timescale 1ns / 1ps

package gbcpu_pkg;

  // Opcodes of the handled subset
  localparam logic [7:0] OP_NOP      = 8'h00;
  localparam logic [7:0] OP_LD_C_N   = 8'h0E;
  localparam logic [7:0] OP_JR_NZ    = 8'h20;
  localparam logic [7:0] OP_LD_HL_NN = 8'h21;
  localparam logic [7:0] OP_LD_SP_NN = 8'h31;
  localparam logic [7:0] OP_LDD_HL_A = 8'h32;
  localparam logic [7:0] OP_LD_A_N   = 8'h3E;
  localparam logic [7:0] OP_LD_HL_A  = 8'h77;
  localparam logic [7:0] OP_XOR_A    = 8'hAF;
  localparam logic [7:0] OP_PREFIX_CB = 8'hCB;
  localparam logic [7:0] OP_LD_IOC_A = 8'hE2;
  // CB sub-opcode for BIT 7,H
  localparam logic [7:0] CB_BIT7_H   = 8'h7C;

  // High byte of the I/O page
  localparam logic [7:0] IO_PAGE = 8'hFF;

  // Flag bit positions
  localparam int unsigned FLAG_Z = 3;
  localparam int unsigned FLAG_N = 2;
  localparam int unsigned FLAG_H = 1;
  localparam int unsigned FLAG_C = 0;

  typedef struct packed {
    logic [7:0] opcode;
    logic [7:0] operand_low;
    logic [7:0] operand_high;
  } instr_t;

  typedef struct packed {
    logic [7:0]  acc;
    logic [7:0]  reg_c;
    logic [15:0] hl;
    logic [15:0] sp;
    logic [15:0] pc;
    logic [3:0]  flags;
    logic        halt;
  } arch_t;

  typedef struct packed {
    logic [15:0] next_pc;
    logic        mem_write;
    logic [15:0] mem_addr;
    logic [7:0]  mem_data;
    logic        halted;
    logic        zero_out;
    logic [7:0]  acc_out;
    logic [15:0] hl_out;
    logic [15:0] sp_out;
  } result_t;

endpackage

[rtl/core/gbcpu_chan_if.sv]
// Interfaces: instruction input channel and result channel.
`timescale 1ns / 1ps

interface gbcpu_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] opcode;
  logic [7:0] operand_low;
  logic [7:0] operand_high;

  modport source (output valid, output opcode, output operand_low, output operand_high,
                  input ready);
  modport sink (input valid, input opcode, input operand_low, input operand_high,
                output ready);
endinterface

interface gbcpu_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] next_pc;
  logic        mem_write;
  logic [15:0] mem_addr;
  logic [7:0]  mem_data;
  logic        halted;
  logic        zero_out;
  logic [7:0]  acc_out;
  logic [15:0] hl_out;
  logic [15:0] sp_out;

  modport source (output valid, output next_pc, output mem_write, output mem_addr,
                  output mem_data, output halted, output zero_out, output acc_out,
                  output hl_out, output sp_out, input ready);
  modport sink (input valid, input next_pc, input mem_write, input mem_addr,
                input mem_data, input halted, input zero_out, input acc_out,
                input hl_out, input sp_out, output ready);
endinterface

[rtl/core/gbcpu_exec.sv]
// Execute unit: decodes one instruction and computes the next register state and result.
`timescale 1ns / 1ps

module gbcpu_exec import gbcpu_pkg::*; (
  input  arch_t   st,
  input  instr_t  instr,
  output arch_t   st_nxt,
  output result_t res
);

  logic        wr;
  logic [15:0] waddr;
  logic [15:0] imm16;
  logic [15:0] rel_off;

  assign imm16   = {instr.operand_high, instr.operand_low};
  assign rel_off = {{8{instr.operand_low[7]}}, instr.operand_low};

  // Decode and update registers; a halted core holds everything
  always_comb begin
    st_nxt = st;
    wr     = 1'b0;
    waddr  = 16'h0000;
    if (!st.halt) begin
      unique case (instr.opcode)
        OP_NOP: begin
          st_nxt.pc = st.pc + 16'd1;
        end
        OP_LD_C_N: begin
          st_nxt.reg_c = instr.operand_low;
          st_nxt.pc    = st.pc + 16'd2;
        end
        OP_LD_A_N: begin
          st_nxt.acc = instr.operand_low;
          st_nxt.pc  = st.pc + 16'd2;
        end
        OP_LD_HL_NN: begin
          st_nxt.hl = imm16;
          st_nxt.pc = st.pc + 16'd3;
        end
        OP_LD_SP_NN: begin
          st_nxt.sp = imm16;
          st_nxt.pc = st.pc + 16'd3;
        end
        OP_LDD_HL_A: begin
          wr        = 1'b1;
          waddr     = st.hl;
          st_nxt.hl = st.hl - 16'd1;
          st_nxt.pc = st.pc + 16'd1;
        end
        OP_LD_HL_A: begin
          wr        = 1'b1;
          waddr     = st.hl;
          st_nxt.pc = st.pc + 16'd1;
        end
        OP_JR_NZ: begin
          // Take the branch relative to the following instruction
          if (!st.flags[FLAG_Z]) begin
            st_nxt.pc = st.pc + 16'd2 + rel_off;
          end else begin
            st_nxt.pc = st.pc + 16'd2;
          end
        end
        OP_XOR_A: begin
          st_nxt.acc   = 8'h00;
          st_nxt.flags = 4'b0000;
          st_nxt.flags[FLAG_Z] = 1'b1;
          st_nxt.pc    = st.pc + 16'd1;
        end
        OP_LD_IOC_A: begin
          wr        = 1'b1;
          waddr     = {IO_PAGE, st.reg_c};
          st_nxt.pc = st.pc + 16'd1;
        end
        OP_PREFIX_CB: begin
          if (instr.operand_low == CB_BIT7_H) begin
            st_nxt.flags[FLAG_Z] = ~st.hl[15];
            st_nxt.flags[FLAG_N] = 1'b0;
            st_nxt.flags[FLAG_H] = 1'b1;
            st_nxt.pc = st.pc + 16'd2;
          end else begin
            // Unknown CB op: step past the prefix, then stop
            st_nxt.halt = 1'b1;
            st_nxt.pc   = st.pc + 16'd1;
          end
        end
        default: begin
          st_nxt.halt = 1'b1;
        end
      endcase
    end
  end

  // Assemble the result; store fields read zero when nothing is stored
  always_comb begin
    res.next_pc   = st_nxt.pc;
    res.mem_write = wr;
    res.mem_addr  = wr ? waddr : 16'h0000;
    res.mem_data  = wr ? st_nxt.acc : 8'h00;
    res.halted    = st_nxt.halt;
    res.zero_out  = st_nxt.flags[FLAG_Z];
    res.acc_out   = st_nxt.acc;
    res.hl_out    = st_nxt.hl;
    res.sp_out    = st_nxt.sp;
  end

endmodule

[rtl/core/gb_cpu_instruction_subset.sv]
// An instruction passes through the input register and then the result register before its result shows.
// One instruction per cycle while the result is not stalled; the register state feeds back in a single pass.
// A stalled result holds the pipe; the input register and result register each hold one item.
// Reset (rst_n low, synchronous) clears the register state and empties the pipe;
// the instruction and result data registers keep their contents.
`timescale 1ns / 1ps
`include "gb_cpu_instruction_subset_assert.svh"

module gb_cpu_instruction_subset import gbcpu_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  gbcpu_in_if.sink    in_chan,
  gbcpu_out_if.source out_chan
);

  logic    in_valid_r;
  instr_t  instr_r;
  arch_t   st_r;
  arch_t   st_nxt;
  logic    out_valid_r;
  result_t res_r;
  result_t res_nxt;
  logic    exec_adv;
  logic    in_fire;

  // Advance the execute stage when the result register is free or draining
  assign exec_adv = !out_valid_r || out_chan.ready;
  assign in_chan.ready = !in_valid_r || exec_adv;
  assign in_fire = in_chan.valid && in_chan.ready;

  gbcpu_exec u_exec (
    .st     (st_r),
    .instr  (instr_r),
    .st_nxt (st_nxt),
    .res    (res_nxt)
  );

  // Input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_chan.ready) begin
      in_valid_r <= in_chan.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      instr_r <= '{opcode: in_chan.opcode, operand_low: in_chan.operand_low,
                   operand_high: in_chan.operand_high};
    end
  end

  // Architectural state: commit when an instruction leaves the execute stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= '0;
    end else if (in_valid_r && exec_adv) begin
      st_r <= st_nxt;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (exec_adv) begin
      out_valid_r <= in_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid_r && exec_adv) begin
      res_r <= res_nxt;
    end
  end

  assign out_chan.valid     = out_valid_r;
  assign out_chan.next_pc   = res_r.next_pc;
  assign out_chan.mem_write = res_r.mem_write;
  assign out_chan.mem_addr  = res_r.mem_addr;
  assign out_chan.mem_data  = res_r.mem_data;
  assign out_chan.halted    = res_r.halted;
  assign out_chan.zero_out  = res_r.zero_out;
  assign out_chan.acc_out   = res_r.acc_out;
  assign out_chan.hl_out    = res_r.hl_out;
  assign out_chan.sp_out    = res_r.sp_out;

  // Halt is sticky once set
  `GBCPU_ASSERT(a_halt_sticky, clk, rst_n, st_r.halt |=> st_r.halt)
  // A halted core never moves the PC
  `GBCPU_ASSERT(a_halt_pc_hold, clk, rst_n, st_r.halt |=> $stable(st_r.pc))
  // No store means zero address and data on a shown result
  `GBCPU_ASSERT(a_nostore_zero, clk, rst_n, (out_valid_r && !res_r.mem_write) |-> (res_r.mem_addr == 16'h0000 && res_r.mem_data == 8'h00))
  // Full pipe with a stalled result refuses new transfers
  `GBCPU_ASSERT(a_full_stall, clk, rst_n, (in_valid_r && out_valid_r && !out_chan.ready) |-> !in_chan.ready)
  // Reset empties both stages
  `GBCPU_ASSERT_ALWAYS(a_reset_empty, clk, !rst_n |=> (!in_valid_r && !out_valid_r))

endmodule

[bench/testbench.sv]
// Self-checking testbench of the instruction execute block: directed and random programs.
`timescale 1ns / 1ps

module testbench;
  import gbcpu_pkg::*;

  localparam int TAIL_ITEMS     = 60;   // last stretch of the run with no idling
  localparam int RANDOM_ITEMS   = 420;
  localparam int HALTED_ITEMS   = 10;
  localparam int WATCHDOG_LIMIT = 400;
  localparam int MAX_REPORTS    = 10;

  logic clk = 1'b0;
  logic rst_n;

  gbcpu_in_if  in_chan ();
  gbcpu_out_if out_chan ();

  gb_cpu_instruction_subset dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .out_chan (out_chan)
  );

  // Predictor state, queues and counters
  arch_t   arch_state;
  instr_t  instr_stream[$];
  result_t predicted_results[$];
  int      mismatches = 0;
  int      gap_left = 0;
  int      stall_left = 0;
  int      idle_cycles = 0;
  logic    tail_phase = 1'b0;

  // Clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic logic is_handled(logic [7:0] op);
    case (op)
      OP_NOP, OP_LD_C_N, OP_JR_NZ, OP_LD_HL_NN, OP_LD_SP_NN, OP_LDD_HL_A,
      OP_LD_A_N, OP_LD_HL_A, OP_XOR_A, OP_PREFIX_CB, OP_LD_IOC_A: return 1'b1;
      default: return 1'b0;
    endcase
  endfunction

  // Bias toward the byte extremes a quarter of the time
  function automatic logic [7:0] rand_byte();
    case ($urandom_range(0, 7))
      0: return 8'h00;
      1: return 8'hFF;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  // Execute one instruction on the predicted architectural state
  function automatic result_t execute_instr(instr_t ins);
    result_t     res;
    logic [15:0] pc_next;
    res = '0;
    if (!arch_state.halt) begin
      pc_next = arch_state.pc;
      case (ins.opcode)
        OP_NOP: pc_next = arch_state.pc + 16'd1;
        OP_LD_C_N: begin
          arch_state.reg_c = ins.operand_low;
          pc_next = arch_state.pc + 16'd2;
        end
        OP_LD_A_N: begin
          arch_state.acc = ins.operand_low;
          pc_next = arch_state.pc + 16'd2;
        end
        OP_LD_HL_NN: begin
          arch_state.hl = {ins.operand_high, ins.operand_low};
          pc_next = arch_state.pc + 16'd3;
        end
        OP_LD_SP_NN: begin
          arch_state.sp = {ins.operand_high, ins.operand_low};
          pc_next = arch_state.pc + 16'd3;
        end
        OP_LDD_HL_A: begin
          res.mem_write = 1'b1;
          res.mem_addr  = arch_state.hl;
          res.mem_data  = arch_state.acc;
          arch_state.hl = arch_state.hl - 16'd1;
          pc_next = arch_state.pc + 16'd1;
        end
        OP_LD_HL_A: begin
          res.mem_write = 1'b1;
          res.mem_addr  = arch_state.hl;
          res.mem_data  = arch_state.acc;
          pc_next = arch_state.pc + 16'd1;
        end
        OP_JR_NZ: begin
          pc_next = arch_state.pc + 16'd2;
          if (!arch_state.flags[FLAG_Z])
            pc_next = pc_next + {{8{ins.operand_low[7]}}, ins.operand_low};
        end
        OP_XOR_A: begin
          arch_state.acc = 8'h00;
          arch_state.flags = '0;
          arch_state.flags[FLAG_Z] = 1'b1;
          pc_next = arch_state.pc + 16'd1;
        end
        OP_LD_IOC_A: begin
          res.mem_write = 1'b1;
          res.mem_addr  = {IO_PAGE, arch_state.reg_c};
          res.mem_data  = arch_state.acc;
          pc_next = arch_state.pc + 16'd1;
        end
        OP_PREFIX_CB: begin
          if (ins.operand_low == CB_BIT7_H) begin
            // carry is kept
            arch_state.flags[FLAG_Z] = ~arch_state.hl[15];
            arch_state.flags[FLAG_N] = 1'b0;
            arch_state.flags[FLAG_H] = 1'b1;
            pc_next = arch_state.pc + 16'd2;
          end else begin
            arch_state.halt = 1'b1;
            pc_next = arch_state.pc + 16'd1;
          end
        end
        default: arch_state.halt = 1'b1;
      endcase
      arch_state.pc = pc_next;
    end
    res.next_pc  = arch_state.pc;
    res.halted   = arch_state.halt;
    res.zero_out = arch_state.flags[FLAG_Z];
    res.acc_out  = arch_state.acc;
    res.hl_out   = arch_state.hl;
    res.sp_out   = arch_state.sp;
    return res;
  endfunction

  task automatic queue_instr(logic [7:0] op, logic [7:0] lo, logic [7:0] hi);
    instr_t ins;
    ins.opcode       = op;
    ins.operand_low  = lo;
    ins.operand_high = hi;
    instr_stream.push_back(ins);
  endtask

  task automatic check_field(string name, logic [15:0] want, logic [15:0] got);
    if (want !== got) begin
      mismatches++;
      if (mismatches <= MAX_REPORTS)
        $display("%0t: %s mismatch: expected %h, got %h", $time, name, want, got);
    end
  endtask

  // Build the program, run reset, wait for the drain
  initial begin
    logic [7:0] op;
    logic [7:0] lo;
    rst_n = 1'b0;
    in_chan.valid = 1'b0;
    in_chan.opcode = '0;
    in_chan.operand_low = '0;
    in_chan.operand_high = '0;
    out_chan.ready = 1'b0;
    arch_state = '0;

    // Directed: PC wrap both ways, HL wrap, I/O page ends, BIT on both H values
    queue_instr(OP_JR_NZ, 8'h80, 8'h00);
    queue_instr(OP_JR_NZ, 8'h7F, 8'hFF);
    queue_instr(OP_NOP, 8'hFF, 8'hFF);
    queue_instr(OP_LDD_HL_A, 8'h00, 8'h00);
    queue_instr(OP_LD_A_N, 8'hFF, 8'h00);
    queue_instr(OP_LD_HL_A, 8'h00, 8'h00);
    queue_instr(OP_LD_C_N, 8'hFF, 8'h00);
    queue_instr(OP_LD_IOC_A, 8'h00, 8'h00);
    queue_instr(OP_LD_C_N, 8'h00, 8'hFF);
    queue_instr(OP_LD_IOC_A, 8'hFF, 8'hFF);
    queue_instr(OP_PREFIX_CB, CB_BIT7_H, 8'h00);
    queue_instr(OP_LD_HL_NN, 8'hFF, 8'h7F);
    queue_instr(OP_PREFIX_CB, CB_BIT7_H, 8'hFF);
    queue_instr(OP_JR_NZ, 8'h80, 8'h00);
    queue_instr(OP_LD_SP_NN, 8'hFF, 8'hFF);
    queue_instr(OP_LD_SP_NN, 8'h00, 8'h00);
    queue_instr(OP_LD_HL_NN, 8'h00, 8'h80);
    queue_instr(OP_PREFIX_CB, CB_BIT7_H, 8'h00);
    queue_instr(OP_JR_NZ, 8'h00, 8'h00);
    queue_instr(OP_XOR_A, 8'hFF, 8'hFF);
    queue_instr(OP_JR_NZ, 8'h7F, 8'h00);
    queue_instr(OP_LD_A_N, 8'h00, 8'hFF);
    queue_instr(OP_LD_HL_A, 8'hFF, 8'hFF);

    // Random programs of handled instructions only; a halt would end the useful run
    repeat (RANDOM_ITEMS) begin
      do op = 8'($urandom_range(0, 255)); while (!is_handled(op));
      lo = (op == OP_PREFIX_CB) ? CB_BIT7_H : rand_byte();
      queue_instr(op, lo, rand_byte());
    end

    // Halt once, through an unhandled opcode or an unhandled CB sub-opcode
    if ($urandom_range(0, 1) == 0) begin
      do op = 8'($urandom_range(0, 255)); while (is_handled(op));
      queue_instr(op, rand_byte(), rand_byte());
    end else begin
      do lo = 8'($urandom_range(0, 255)); while (lo == CB_BIT7_H);
      queue_instr(OP_PREFIX_CB, lo, rand_byte());
    end

    // Anything goes once halted
    repeat (HALTED_ITEMS) queue_instr(rand_byte(), rand_byte(), rand_byte());

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    while (instr_stream.size() != 0 || predicted_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);

    if (mismatches == 0 && predicted_results.size() == 0)
      $display("Simulation PASSED");
    else
      $display("Simulation FAILED");
    $finish;
  end

  // Driver: offer the head of the stream, predict on each transfer
  always @(posedge clk) begin : drive_proc
    instr_t head;
    logic   offer;
    if (!rst_n) begin
      in_chan.valid <= 1'b0;
      gap_left = 0;
    end else begin
      if (in_chan.valid && in_chan.ready) begin
        head = instr_stream.pop_front();
        predicted_results.push_back(execute_instr(head));
      end
      if (!in_chan.valid || in_chan.ready) begin
        offer = 1'b0;
        if (gap_left > 0) begin
          gap_left--;
        end else if (instr_stream.size() != 0) begin
          if (!tail_phase && $urandom_range(0, 9) == 0)
            gap_left = $urandom_range(0, 7);
          else
            offer = 1'b1;
        end
        in_chan.valid <= offer;
        if (offer) begin
          in_chan.opcode       <= instr_stream[0].opcode;
          in_chan.operand_low  <= instr_stream[0].operand_low;
          in_chan.operand_high <= instr_stream[0].operand_high;
        end
      end
      tail_phase <= (instr_stream.size() <= TAIL_ITEMS);
    end
  end

  // Monitor: stall in bursts, check each result transfer against the oldest prediction
  always @(posedge clk) begin : monitor_proc
    result_t want;
    if (!rst_n) begin
      out_chan.ready <= 1'b0;
      stall_left = 0;
    end else begin
      if (out_chan.valid && out_chan.ready) begin
        if (predicted_results.size() == 0) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS)
            $display("%0t: result transfer with no prediction pending", $time);
        end else begin
          want = predicted_results.pop_front();
          check_field("next_pc", want.next_pc, out_chan.next_pc);
          check_field("mem_write", 16'(want.mem_write), 16'(out_chan.mem_write));
          check_field("mem_addr", want.mem_addr, out_chan.mem_addr);
          check_field("mem_data", 16'(want.mem_data), 16'(out_chan.mem_data));
          check_field("halted", 16'(want.halted), 16'(out_chan.halted));
          check_field("zero_out", 16'(want.zero_out), 16'(out_chan.zero_out));
          check_field("acc_out", 16'(want.acc_out), 16'(out_chan.acc_out));
          check_field("hl_out", want.hl_out, out_chan.hl_out);
          check_field("sp_out", want.sp_out, out_chan.sp_out);
        end
      end
      if (stall_left > 0) begin
        stall_left--;
        out_chan.ready <= 1'b0;
      end else if (!tail_phase && $urandom_range(0, 9) == 0) begin
        stall_left = $urandom_range(0, 7);
        out_chan.ready <= 1'b0;
      end else begin
        out_chan.ready <= 1'b1;
      end
    end
  end

  // Watchdog: end the run when nothing transfers for too long
  always @(posedge clk) begin
    if (!rst_n || (in_chan.valid && in_chan.ready) || (out_chan.valid && out_chan.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

endmodule

[files.f]
+incdir+rtl/core
rtl/core/gbcpu_pkg.sv
rtl/core/gbcpu_chan_if.sv
rtl/core/gbcpu_exec.sv
rtl/core/gb_cpu_instruction_subset.sv
bench/testbench.sv
